### hdl/bcd_cc_pkg.sv
// ----------------------------------------------------------------------------
// bcd_cc_pkg
// Types, codes and helpers shared by the BCD calendar clock files.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_cc_pkg;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // month numbers with a short length
    localparam logic [4:0] MONTH_FEB = 5'd2;
    localparam logic [4:0] MONTH_APR = 5'd4;
    localparam logic [4:0] MONTH_JUN = 5'd6;
    localparam logic [4:0] MONTH_SEP = 5'd9;
    localparam logic [4:0] MONTH_NOV = 5'd11;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [4:0] DAY_LEAP   = 5'd29;

    // reciprocal of ten: (v * 205) >> 11 is exact for v below 1024
    localparam logic [14:0] RECIP_TEN   = 15'd205;
    localparam int          RECIP_SHIFT = 11;

    // one input item
    typedef struct packed {
        logic       operation;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [4:0] new_day;
        logic [3:0] new_month;
        logic [6:0] new_year;
    } t_in_item;

    // ten digits of time and date, also the result item
    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [1:0] day_tens;
        logic [3:0] day_units;
        logic       month_tens;
        logic [3:0] month_units;
        logic [3:0] year_tens;
        logic [3:0] year_units;
    } t_digits;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_split;

    // binary value up to 127 into tens and units
    function automatic t_split split_ten(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        t_split      res;
        prod      = 15'(value) * RECIP_TEN;
        quot      = prod[RECIP_SHIFT +: 4];
        rem       = value - (7'(quot) * 7'd10);
        res.tens  = quot;
        res.units = rem[3:0];
        return res;
    endfunction

    // days in a month, unknown month numbers count as long months
    function automatic logic [4:0] month_len_of(input logic [4:0] month);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = DAYS_FEB;
            MONTH_APR: len = DAYS_SHORT;
            MONTH_JUN: len = DAYS_SHORT;
            MONTH_SEP: len = DAYS_SHORT;
            MONTH_NOV: len = DAYS_SHORT;
            default:   len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### hdl/bcd_cc_if.sv
// ----------------------------------------------------------------------------
// bcd_cc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcd_cc_in_if;
    import bcd_cc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bcd_cc_out_if;
    import bcd_cc_pkg::*;

    logic    valid;
    logic    ready;
    t_digits payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/bcd_calendar_clock_core.sv
// A transfer accepted at the input goes to the input register, then to the result
// register, which presents its result on o_out.
// Throughput: one item per cycle; the combinational carry chain in bcd_cc_next
// sets the pace, and the result register keeps taking items while not stalled.
// Reset (synchronous, active low) sets 00:00 on 01.01.00 and empties both stages.
// ----------------------------------------------------------------------------
// bcd_calendar_clock_core
// BCD time and date keeper: minute ticks and loads, one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_calendar_clock_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bcd_cc_in_if.sink    i_in,
    bcd_cc_out_if.source o_out
);
    import bcd_cc_pkg::*;

    localparam t_digits RESET_DIGITS = '{
        hour_tens:    2'd0,
        hour_units:   4'd0,
        minute_tens:  3'd0,
        minute_units: 4'd0,
        day_tens:     2'd0,
        day_units:    4'd1,
        month_tens:   1'b0,
        month_units:  4'd1,
        year_tens:    4'd0,
        year_units:   4'd0
    };

    t_in_item r_in;
    logic     r_in_valid;
    t_digits  r_state;
    t_digits  n_state;
    t_digits  r_out;
    logic     r_out_valid;
    logic     advance;

    // item moves from input register to result register
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // next digits
    bcd_cc_next u_next (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
    end

    // digit state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= RESET_DIGITS;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_state;
        end
    end

    // result register carries the state just written
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && (r_out == r_state)))
        else $error("result register differs from digit state");

    // units digits never leave the decimal range
    a_units_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.minute_units <= 4'd9) && (r_state.hour_units <= 4'd9)
        && (r_state.day_units <= 4'd9) && (r_state.month_units <= 4'd9)
        && (r_state.year_units <= 4'd9))
        else $error("units digit above nine");

    // a tick without a minute carry only bumps the minute units
    a_tick_no_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.operation == OP_TICK) && (r_state.minute_units != 4'd9))
        |=> ((r_state.minute_units == 4'($past(r_state.minute_units) + 4'd1))
             && (r_state.hour_units == $past(r_state.hour_units))
             && (r_state.day_units == $past(r_state.day_units))))
        else $error("tick without carry changed more than minute units");

    // state only changes when an item passes through
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("digit state changed without an item");

endmodule

`default_nettype wire

### hdl/bcd_cc_next.sv
// ----------------------------------------------------------------------------
// bcd_cc_next
// Next digits for one item: load split into digits, or one-minute carry chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_cc_next (
    input  wire bcd_cc_pkg::t_digits  i_state,
    input  wire bcd_cc_pkg::t_in_item i_item,
    output bcd_cc_pkg::t_digits       o_state
);
    import bcd_cc_pkg::*;

    // load values split into digits
    t_split hour_sp;
    t_split minute_sp;
    t_split day_sp;
    t_split month_sp;
    t_split year_sp;

    assign hour_sp   = split_ten(7'(i_item.new_hour));
    assign minute_sp = split_ten(7'(i_item.new_minute));
    assign day_sp    = split_ten(7'(i_item.new_day));
    assign month_sp  = split_ten(7'(i_item.new_month));
    assign year_sp   = split_ten(i_item.new_year);

    // minute stage
    logic [4:0] min_u1;
    logic       min_wrap;
    logic [3:0] min_t1;
    logic       hr_carry;

    assign min_u1   = {1'b0, i_state.minute_units} + 5'd1;
    assign min_wrap = (min_u1 >= 5'd10);
    assign min_t1   = {1'b0, i_state.minute_tens} + 4'd1;
    assign hr_carry = min_wrap && (min_t1 >= 4'd6);

    // hour stage
    logic [4:0] hr_u1;
    logic       hr_wrap;
    logic [3:0] hr_u_new;
    logic [2:0] hr_t_new;
    logic [5:0] hr_val;
    logic       day_carry;

    assign hr_u1     = {1'b0, i_state.hour_units} + 5'd1;
    assign hr_wrap   = (hr_u1 >= 5'd10);
    assign hr_u_new  = hr_wrap ? 4'(hr_u1 - 5'd10) : hr_u1[3:0];
    assign hr_t_new  = {1'b0, i_state.hour_tens} + {2'b00, hr_wrap};
    assign hr_val    = (6'(hr_t_new) * 6'd10) + 6'(hr_u_new);
    assign day_carry = hr_carry && (hr_val >= 6'd24);

    // day stage, with leap day in february of years divisible by four
    logic [4:0] day_u1;
    logic       day_wrap;
    logic [3:0] day_u_new;
    logic [2:0] day_t_new;
    logic [5:0] day_val;
    logic [4:0] mon_cur;
    logic [4:0] mon_len;
    logic [3:0] yr_mod;
    logic       leap_keep;
    logic       mon_carry;

    assign day_u1    = {1'b0, i_state.day_units} + 5'd1;
    assign day_wrap  = (day_u1 >= 5'd10);
    assign day_u_new = day_wrap ? 4'(day_u1 - 5'd10) : day_u1[3:0];
    assign day_t_new = {1'b0, i_state.day_tens} + {2'b00, day_wrap};
    assign day_val   = (6'(day_t_new) * 6'd10) + 6'(day_u_new);
    assign mon_cur   = (5'(i_state.month_tens) * 5'd10) + 5'(i_state.month_units);
    assign mon_len   = month_len_of(mon_cur);
    // ten is two modulo four
    assign yr_mod    = {i_state.year_tens[2:0], 1'b0} + i_state.year_units;
    assign leap_keep = (mon_cur == MONTH_FEB) && (yr_mod[1:0] == 2'b00)
                       && (day_val == 6'(DAY_LEAP));
    assign mon_carry = day_carry && (day_val > 6'(mon_len)) && !leap_keep;

    // month stage
    logic [4:0] mon_u1;
    logic       mon_wrap;
    logic [3:0] mon_u_new;
    logic [1:0] mon_t_new;
    logic [4:0] mon_val;
    logic       yr_carry;

    assign mon_u1    = {1'b0, i_state.month_units} + 5'd1;
    assign mon_wrap  = (mon_u1 >= 5'd10);
    assign mon_u_new = mon_wrap ? 4'(mon_u1 - 5'd10) : mon_u1[3:0];
    assign mon_t_new = {1'b0, i_state.month_tens} + {1'b0, mon_wrap};
    assign mon_val   = (5'(mon_t_new) * 5'd10) + 5'(mon_u_new);
    assign yr_carry  = mon_carry && (mon_val >= 5'd13);

    // year stage
    logic [4:0] yr_u1;
    logic       yr_wrap;
    logic [4:0] yr_t1;

    assign yr_u1   = {1'b0, i_state.year_units} + 5'd1;
    assign yr_wrap = (yr_u1 >= 5'd10);
    assign yr_t1   = {1'b0, i_state.year_tens} + 5'd1;

    // select the new digits
    always_comb begin
        o_state = i_state;
        if (i_item.operation == OP_LOAD) begin
            o_state.hour_tens    = hour_sp.tens[1:0];
            o_state.hour_units   = hour_sp.units;
            o_state.minute_tens  = minute_sp.tens[2:0];
            o_state.minute_units = minute_sp.units;
            o_state.day_tens     = day_sp.tens[1:0];
            o_state.day_units    = day_sp.units;
            o_state.month_tens   = month_sp.tens[0];
            o_state.month_units  = month_sp.units;
            o_state.year_tens    = year_sp.tens;
            o_state.year_units   = year_sp.units;
        end else begin
            if (min_wrap) begin
                o_state.minute_units = 4'(min_u1 - 5'd10);
                o_state.minute_tens  = hr_carry ? 3'd0 : min_t1[2:0];
            end else begin
                o_state.minute_units = min_u1[3:0];
            end
            if (hr_carry) begin
                o_state.hour_tens  = day_carry ? 2'd0 : hr_t_new[1:0];
                o_state.hour_units = day_carry ? 4'd0 : hr_u_new;
            end
            if (day_carry) begin
                o_state.day_tens  = mon_carry ? 2'd0 : day_t_new[1:0];
                o_state.day_units = mon_carry ? 4'd1 : day_u_new;
            end
            if (mon_carry) begin
                o_state.month_tens  = yr_carry ? 1'b0 : mon_t_new[0];
                o_state.month_units = yr_carry ? 4'd1 : mon_u_new;
            end
            if (yr_carry) begin
                o_state.year_units = yr_wrap ? 4'(yr_u1 - 5'd10) : yr_u1[3:0];
                if (yr_wrap) begin
                    o_state.year_tens = (yr_t1 >= 5'd10) ? 4'd0 : yr_t1[3:0];
                end
            end
        end
    end

endmodule

`default_nettype wire
